// File: sv/cpe_pkg.sv
// Shared constants, codes and controller/datapath command types for the
// cover position estimator. No dependencies.
package cpe_pkg;

   localparam int PosBits    = 16;
   localparam int TimeBits   = 32;
   localparam int DurBits    = 20;
   localparam int CmpW       = (TimeBits > DurBits) ? TimeBits : DurBits;
   localparam int DivCntW    = $clog2(PosBits);
   localparam int FieldPosW  = 16;
   localparam int FieldTimeW = 32;
   localparam int MaxRes     = 4;
   localparam int ResIdxW    = $clog2(MaxRes);
   localparam int ResCntW    = ResIdxW + 1;
   localparam int AddrW      = 4;

   localparam logic [PosBits-1:0] PosMax       = '1;
   localparam longint             PosMaxL      = (64'd1 << PosBits) - 1;
   localparam logic [PosBits-1:0] LockStartPos = PosBits'((PosMaxL * 2) / 10);
   localparam logic [DurBits-1:0] DurMax       = '1;
   localparam int                 FullCloseReset = 60000;
   localparam logic [DurBits-1:0] FullCloseInit  = DurBits'(FullCloseReset);
   localparam logic [DurBits-1:0] DurTravelReset = DurBits'((FullCloseReset * 7) / 10);
   localparam logic [DurBits-1:0] DurLockReset   = DurBits'((FullCloseReset * 3) / 10);
   localparam int                 PubHoldMs      = 1000;

   // floor(y/10) = (y * Recip10) >> Recip10Shift for y below 2^26
   localparam int               Recip10W     = 24;
   localparam logic [23:0]      Recip10      = 24'd13421773;
   localparam int               Recip10Shift = 27;

   localparam logic [1:0] StUnlocked = 2'd1;
   localparam logic [1:0] StStrong   = 2'd2;
   localparam logic [1:0] StWeak     = 2'd3;

   typedef enum logic [1:0] {
      MOT_IDLE  = 2'd0,
      MOT_OPEN  = 2'd1,
      MOT_CLOSE = 2'd2
   } motion_type;

   typedef enum logic [1:0] {
      MCMD_NONE  = 2'd0,
      MCMD_STOP  = 2'd1,
      MCMD_OPEN  = 2'd2,
      MCMD_CLOSE = 2'd3
   } mcmd_type;

   typedef enum logic [1:0] {
      CSR_STATUS_LEADING = 2'd0,
      CSR_AUTO_CAL       = 2'd1,
      CSR_FULL_CLOSE     = 2'd2
   } csr_idx_type;

   typedef enum logic [4:0] {
      DP_NOP,
      DP_LATCH,
      DP_DIV_LOCK,
      DP_DIV_OPEN,
      DP_DIV_CLOSE,
      DP_LOCK_ADD,
      DP_WIN_ADD,
      DP_WIN_SUB,
      DP_LOCK_SUB,
      DP_RC_DONE,
      DP_START,
      DP_SET_CLOSED,
      DP_CALIB,
      DP_UNLOCK_START,
      DP_FREE,
      DP_OPEN_END,
      DP_CLOSE_END,
      DP_AT_MAX,
      DP_PRIOR_WIN,
      DP_GOAL_MAX,
      DP_GOAL_ZERO,
      DP_GOAL_REQ,
      DP_EMIT,
      DP_CLEAR
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      motion_type dir;
      mcmd_type   mcmd;
      logic       ready;
      logic       drain;
   } dp_cmd_type;

   typedef struct packed {
      logic       req_valid;
      logic       req_kind;
      logic       status_leading;
      logic       auto_cal;
      motion_type motion;
      motion_type prior_motion;
      logic       lock_freed;
      logic       win_zero;
      logic       prior_max;
      logic       locked;
      logic       unlocked;
      logic       pub_ok;
      logic       open_due;
      logic       close_due;
      logic       at_goal;
      logic       goal_zero;
      logic       goal_max;
      logic       stop_req;
      logic       toggle_req;
      logic       pos_valid;
      logic       p_eq_win;
      logic       p_lt_win;
      logic       p_zero;
      logic       p_max;
      logic       div_busy;
      logic       pending;
   } dp_stat_type;

   typedef struct packed {
      mcmd_type             mcmd;
      logic                 publish;
      logic [PosBits-1:0]   pos;
      logic [PosBits-1:0]   lock;
      motion_type           motion;
   } res_item_type;

endpackage

// File: sv/cpe_if.sv
// Request and result channel interfaces for the cover position estimator.
// Depends on cpe_pkg.
interface cpe_req_if import cpe_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  kind;
   logic [FieldTimeW-1:0] now_ms;
   logic [1:0]            status_code;
   logic                  stop_request;
   logic                  toggle_request;
   logic                  position_valid;
   logic [FieldPosW-1:0]  requested_position;

   modport source (output valid, kind, now_ms, status_code, stop_request, toggle_request,
                   position_valid, requested_position, input ready);
   modport sink (input valid, kind, now_ms, status_code, stop_request, toggle_request,
                 position_valid, requested_position, output ready);
endinterface

interface cpe_rsp_if import cpe_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [1:0]           motor_command;
   logic                 publish;
   logic [FieldPosW-1:0] position;
   logic [FieldPosW-1:0] lock_position;
   logic [1:0]           operation;
   logic                 last;

   modport source (output valid, motor_command, publish, position, lock_position,
                   operation, last, input ready);
   modport sink (input valid, motor_command, publish, position, lock_position,
                 operation, last, output ready);
endinterface

// File: sv/cpe_div.sv
// Sequential divider: floor(el * PosMax / dur), saturated to PosMax.
// Depends on cpe_pkg.
module cpe_div import cpe_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [TimeBits-1:0] el,
   input  logic [DurBits-1:0]  dur,
   output logic                busy,
   output logic [PosBits-1:0]  quo
);

   typedef enum logic [1:0] {DV_IDLE, DV_CHECK, DV_RUN} dv_state_type;

   dv_state_type                  st_ff, st_in;
   logic [TimeBits+PosBits-1:0]   num_ff, num_in;
   logic [PosBits-1:0]            lo_ff, lo_in;
   logic [DurBits-1:0]            rem_ff, rem_in;
   logic [DurBits-1:0]            dur_ff, dur_in;
   logic [PosBits-1:0]            quo_ff, quo_in;
   logic [DivCntW-1:0]            cnt_ff, cnt_in;
   logic [TimeBits-1:0]           hi;
   logic [DurBits:0]              trial;
   logic                          take;

   assign hi    = num_ff[TimeBits+PosBits-1:PosBits];
   assign trial = {rem_ff, lo_ff[PosBits-1]};
   assign take  = trial >= {1'b0, dur_ff};
   assign busy  = st_ff != DV_IDLE;
   assign quo   = quo_ff;

   always_comb begin
      st_in  = st_ff;
      num_in = num_ff;
      lo_in  = lo_ff;
      rem_in = rem_ff;
      dur_in = dur_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      unique case (st_ff)
         DV_IDLE: begin
            if (start) begin
               // el * (2^PosBits - 1) as a shift and subtract
               num_in = {el, PosBits'(0)} - (TimeBits+PosBits)'(el);
               dur_in = dur;
               st_in  = DV_CHECK;
            end
         end
         DV_CHECK: begin
            if (CmpW'(hi) >= CmpW'(dur_ff)) begin
               quo_in = PosMax;
               st_in  = DV_IDLE;
            end else begin
               rem_in = DurBits'(hi);
               lo_in  = num_ff[PosBits-1:0];
               cnt_in = '0;
               st_in  = DV_RUN;
            end
         end
         DV_RUN: begin
            rem_in = take ? DurBits'(trial - {1'b0, dur_ff}) : DurBits'(trial);
            quo_in = {quo_ff[PosBits-2:0], take};
            lo_in  = {lo_ff[PosBits-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DivCntW'(PosBits - 1)) begin
               st_in = DV_IDLE;
            end
         end
         default: st_in = DV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= DV_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      lo_ff  <= lo_in;
      rem_ff <= rem_in;
      dur_ff <= dur_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

endmodule

// File: sv/cpe_dp.sv
// Datapath: position state, timestamps, durations, config registers,
// result buffer and the divider. Depends on cpe_pkg, cpe_if and cpe_div.
module cpe_dp import cpe_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  dp_cmd_type         cmd,
   output dp_stat_type        stat,
   cpe_req_if.sink            req,
   cpe_rsp_if.source          rsp,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [AddrW-1:0]   paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata
);

   function automatic logic [DurBits-1:0] dur_frac(input logic [DurBits-1:0] x,
                                                   input logic [2:0] k);
      logic [DurBits+2:0]          y;
      logic [DurBits+2+Recip10W:0] p;
      y = (DurBits+3)'(x) * (DurBits+3)'(k);
      p = (DurBits+3+Recip10W)'(y) * (DurBits+3+Recip10W)'(Recip10);
      return DurBits'(p >> Recip10Shift);
   endfunction

   function automatic logic [PosBits-1:0] sat_add(input logic [PosBits-1:0] a,
                                                  input logic [PosBits-1:0] b);
      logic [PosBits:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[PosBits] ? PosMax : s[PosBits-1:0];
   endfunction

   function automatic logic [PosBits-1:0] sat_sub(input logic [PosBits-1:0] a,
                                                  input logic [PosBits-1:0] b);
      return (b >= a) ? '0 : a - b;
   endfunction

   // configuration
   logic                sl_ff, sl_in;
   logic                acal_ff, acal_in;
   logic [DurBits-1:0]  full_ff, full_in;
   logic [DurBits-1:0]  open_ms_ff, open_ms_in;
   logic [DurBits-1:0]  close_ms_ff, close_ms_in;
   logic [DurBits-1:0]  lock_ms_ff, lock_ms_in;
   // estimator state
   logic [PosBits-1:0]  win_ff, win_in;
   logic [PosBits-1:0]  lock_ff, lock_in;
   logic [PosBits-1:0]  prior_ff, prior_in;
   logic [PosBits-1:0]  goal_ff, goal_in;
   motion_type          motion_ff, motion_in;
   motion_type          pmotion_ff, pmotion_in;
   logic                freed_ff, freed_in;
   logic [TimeBits-1:0] open_start_ff, open_start_in;
   logic [TimeBits-1:0] close_start_ff, close_start_in;
   logic [TimeBits-1:0] recomp_ff, recomp_in;
   logic [TimeBits-1:0] pub_ff, pub_in;
   // latched item
   logic [TimeBits-1:0] now_ff, now_in;
   logic [1:0]          stcode_ff, stcode_in;
   logic                stop_ff, stop_in;
   logic                tog_ff, tog_in;
   logic                posv_ff, posv_in;
   logic [PosBits-1:0]  rpos_ff, rpos_in;
   // result buffer
   res_item_type        res_ff [MaxRes];
   res_item_type        res_new;
   logic                res_wr;
   logic [ResCntW-1:0]  cnt_ff, cnt_in;
   logic [ResCntW-1:0]  rd_ff, rd_in;

   logic                cfg_wr;
   logic                full_wr;
   logic                set_en;
   logic [DurBits-1:0]  set_x;
   logic [TimeBits-1:0] meas;
   logic [DurBits-1:0]  cal_x;
   logic [TimeBits-1:0] el;
   logic [DurBits-1:0]  div_dur;
   logic                div_start;
   logic                div_busy;
   logic [PosBits-1:0]  quo;
   logic                at_goal;
   res_item_type        rd_item;

   cpe_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .el    (el),
      .dur   (div_dur),
      .busy  (div_busy),
      .quo   (quo)
   );

   assign el        = now_ff - recomp_ff;
   assign div_start = (cmd.op == DP_DIV_LOCK) || (cmd.op == DP_DIV_OPEN)
                      || (cmd.op == DP_DIV_CLOSE);

   always_comb begin
      priority case (cmd.op)
         DP_DIV_LOCK: div_dur = lock_ms_ff;
         DP_DIV_OPEN: div_dur = open_ms_ff;
         default:     div_dur = close_ms_ff;
      endcase
   end

   // measured close time, saturated before scaling
   assign meas  = now_ff - close_start_ff;
   assign cal_x = (CmpW'(meas) > CmpW'(DurMax)) ? DurMax : DurBits'(meas);

   assign cfg_wr  = psel && penable && pwrite;
   assign full_wr = cfg_wr && (csr_idx_type'(paddr[3:2]) == CSR_FULL_CLOSE);
   assign set_en  = full_wr || (cmd.op == DP_CALIB);
   assign set_x   = full_wr ? pwdata[DurBits-1:0] : cal_x;

   always_comb begin
      unique case (motion_ff)
         MOT_OPEN:  at_goal = win_ff >= goal_ff;
         MOT_CLOSE: at_goal = win_ff <= goal_ff;
         default:   at_goal = 1'b1;
      endcase
   end

   always_comb begin
      unique case (csr_idx_type'(paddr[3:2]))
         CSR_STATUS_LEADING: prdata = 32'(sl_ff);
         CSR_AUTO_CAL:       prdata = 32'(acal_ff);
         CSR_FULL_CLOSE:     prdata = 32'(full_ff);
         default:            prdata = '0;
      endcase
   end

   assign res_new = '{mcmd: cmd.mcmd, publish: cmd.mcmd == MCMD_NONE, pos: win_ff,
                      lock: lock_ff, motion: motion_ff};

   always_comb begin
      sl_in          = sl_ff;
      acal_in        = acal_ff;
      full_in        = full_ff;
      open_ms_in     = open_ms_ff;
      close_ms_in    = close_ms_ff;
      lock_ms_in     = lock_ms_ff;
      win_in         = win_ff;
      lock_in        = lock_ff;
      prior_in       = prior_ff;
      goal_in        = goal_ff;
      motion_in      = motion_ff;
      pmotion_in     = pmotion_ff;
      freed_in       = freed_ff;
      open_start_in  = open_start_ff;
      close_start_in = close_start_ff;
      recomp_in      = recomp_ff;
      pub_in         = pub_ff;
      now_in         = now_ff;
      stcode_in      = stcode_ff;
      stop_in        = stop_ff;
      tog_in         = tog_ff;
      posv_in        = posv_ff;
      rpos_in        = rpos_ff;
      cnt_in         = cnt_ff;
      rd_in          = rd_ff;
      res_wr         = 1'b0;

      unique case (cmd.op)
         DP_LATCH: begin
            now_in    = TimeBits'(req.now_ms);
            stcode_in = req.status_code;
            stop_in   = req.stop_request;
            tog_in    = req.toggle_request;
            posv_in   = req.position_valid;
            rpos_in   = PosBits'(req.requested_position);
         end
         DP_LOCK_ADD: lock_in = sat_add(lock_ff, quo);
         DP_WIN_ADD:  win_in  = sat_add(win_ff, quo);
         DP_WIN_SUB:  win_in  = sat_sub(win_ff, quo);
         DP_LOCK_SUB: lock_in = sat_sub(lock_ff, quo);
         DP_RC_DONE:  recomp_in = now_ff;
         DP_START: begin
            motion_in = cmd.dir;
            recomp_in = now_ff;
            unique case (cmd.dir)
               MOT_OPEN: begin
                  pmotion_in    = MOT_OPEN;
                  open_start_in = now_ff;
                  if (win_ff != '0) begin
                     prior_in = win_ff;
                  end
               end
               MOT_CLOSE: begin
                  pmotion_in     = MOT_CLOSE;
                  close_start_in = now_ff;
                  if (win_ff != PosMax) begin
                     prior_in = win_ff;
                  end
               end
               default: prior_in = win_ff;
            endcase
         end
         DP_SET_CLOSED: begin
            win_in    = '0;
            prior_in  = '0;
            lock_in   = '0;
            freed_in  = 1'b0;
            motion_in = MOT_IDLE;
            pub_in    = now_ff;
         end
         DP_UNLOCK_START: begin
            prior_in      = '0;
            motion_in     = MOT_OPEN;
            lock_in       = LockStartPos;
            open_start_in = now_ff;
            recomp_in     = now_ff;
            pub_in        = now_ff;
         end
         DP_FREE: freed_in = 1'b1;
         DP_OPEN_END: begin
            win_in    = PosMax;
            prior_in  = PosMax;
            motion_in = MOT_IDLE;
            pub_in    = now_ff;
         end
         DP_CLOSE_END: begin
            win_in    = '0;
            prior_in  = '0;
            motion_in = MOT_IDLE;
            pub_in    = now_ff;
         end
         DP_AT_MAX: begin
            motion_in = MOT_IDLE;
            prior_in  = PosMax;
         end
         DP_PRIOR_WIN: prior_in = win_ff;
         DP_GOAL_MAX:  goal_in  = PosMax;
         DP_GOAL_ZERO: goal_in  = '0;
         DP_GOAL_REQ:  goal_in  = rpos_ff;
         DP_EMIT: begin
            if (cnt_ff < ResCntW'(MaxRes)) begin
               res_wr = 1'b1;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         DP_CLEAR: begin
            cnt_in = '0;
            rd_in  = '0;
         end
         default: ;
      endcase

      if (rsp.valid && rsp.ready) begin
         rd_in = rd_ff + 1'b1;
      end

      if (set_en) begin
         open_ms_in  = dur_frac(set_x, 3'd7);
         close_ms_in = dur_frac(set_x, 3'd7);
         lock_ms_in  = dur_frac(set_x, 3'd3);
      end
      if (cfg_wr) begin
         unique case (csr_idx_type'(paddr[3:2]))
            CSR_STATUS_LEADING: sl_in   = pwdata[0];
            CSR_AUTO_CAL:       acal_in = pwdata[0];
            CSR_FULL_CLOSE:     full_in = pwdata[DurBits-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sl_ff          <= 1'b1;
         acal_ff        <= 1'b0;
         full_ff        <= FullCloseInit;
         open_ms_ff     <= DurTravelReset;
         close_ms_ff    <= DurTravelReset;
         lock_ms_ff     <= DurLockReset;
         win_ff         <= '0;
         lock_ff        <= '0;
         prior_ff       <= '0;
         goal_ff        <= '0;
         motion_ff      <= MOT_IDLE;
         pmotion_ff     <= MOT_IDLE;
         freed_ff       <= 1'b0;
         open_start_ff  <= '0;
         close_start_ff <= '0;
         recomp_ff      <= '0;
         pub_ff         <= '0;
         cnt_ff         <= '0;
         rd_ff          <= '0;
      end else begin
         sl_ff          <= sl_in;
         acal_ff        <= acal_in;
         full_ff        <= full_in;
         open_ms_ff     <= open_ms_in;
         close_ms_ff    <= close_ms_in;
         lock_ms_ff     <= lock_ms_in;
         win_ff         <= win_in;
         lock_ff        <= lock_in;
         prior_ff       <= prior_in;
         goal_ff        <= goal_in;
         motion_ff      <= motion_in;
         pmotion_ff     <= pmotion_in;
         freed_ff       <= freed_in;
         open_start_ff  <= open_start_in;
         close_start_ff <= close_start_in;
         recomp_ff      <= recomp_in;
         pub_ff         <= pub_in;
         cnt_ff         <= cnt_in;
         rd_ff          <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff    <= now_in;
      stcode_ff <= stcode_in;
      stop_ff   <= stop_in;
      tog_ff    <= tog_in;
      posv_ff   <= posv_in;
      rpos_ff   <= rpos_in;
      if (res_wr) begin
         res_ff[cnt_ff[ResIdxW-1:0]] <= res_new;
      end
   end

   assign req.ready = cmd.ready;

   assign rd_item           = res_ff[rd_ff[ResIdxW-1:0]];
   assign rsp.valid         = cmd.drain && (rd_ff < cnt_ff);
   assign rsp.motor_command = rd_item.mcmd;
   assign rsp.publish       = rd_item.publish;
   assign rsp.position      = FieldPosW'(rd_item.pos);
   assign rsp.lock_position = FieldPosW'(rd_item.lock);
   assign rsp.operation     = rd_item.motion;
   assign rsp.last          = (rd_ff + 1'b1) == cnt_ff;

   always_comb begin
      stat.req_valid      = req.valid;
      stat.req_kind       = req.kind;
      stat.status_leading = sl_ff;
      stat.auto_cal       = acal_ff;
      stat.motion         = motion_ff;
      stat.prior_motion   = pmotion_ff;
      stat.lock_freed     = freed_ff;
      stat.win_zero       = win_ff == '0;
      stat.prior_max      = prior_ff == PosMax;
      stat.locked         = (stcode_ff == StStrong) || (stcode_ff == StWeak);
      stat.unlocked       = stcode_ff == StUnlocked;
      stat.pub_ok         = TimeBits'(now_ff - pub_ff) > TimeBits'(PubHoldMs);
      stat.open_due       = CmpW'(TimeBits'(now_ff - open_start_ff)) >= CmpW'(open_ms_ff);
      stat.close_due      = CmpW'(TimeBits'(now_ff - close_start_ff)) >= CmpW'(close_ms_ff);
      stat.at_goal        = at_goal;
      stat.goal_zero      = goal_ff == '0;
      stat.goal_max       = goal_ff == PosMax;
      stat.stop_req       = stop_ff;
      stat.toggle_req     = tog_ff;
      stat.pos_valid      = posv_ff;
      stat.p_eq_win       = rpos_ff == win_ff;
      stat.p_lt_win       = rpos_ff < win_ff;
      stat.p_zero         = rpos_ff == '0;
      stat.p_max          = rpos_ff == PosMax;
      stat.div_busy       = div_busy;
      stat.pending        = rd_ff < cnt_ff;
   end

endmodule

// File: sv/cpe_ctrl.sv
// Controller: sequences tick and control items as datapath operations,
// with call and return for the position update and direction change.
// Depends on cpe_pkg.
module cpe_ctrl import cpe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [4:0] {
      S_IDLE,
      S_C_STOP,
      S_C_STOPPUB,
      S_C_TOG,
      S_C_TOGPUB,
      S_C_POS,
      S_T_BEGIN,
      S_T_CLOSE,
      S_T_PUBEND,
      S_T_PUBGO,
      S_T_RC,
      S_T_AT,
      S_T_PRIOR,
      S_SD_CHK,
      S_SD_SET,
      S_SD_EMIT,
      S_RC_CHK,
      S_RC_LOCKA,
      S_RC_DOPEN,
      S_RC_WINA,
      S_RC_WINS,
      S_RC_CHK0,
      S_RC_LOCKS,
      S_RC_END,
      S_DRAIN
   } state_type;

   state_type  state_ff, state_in;
   state_type  rc_ret_ff, rc_ret_in;
   state_type  sd_ret_ff, sd_ret_in;
   motion_type sd_dir_ff, sd_dir_in;

   always_comb begin
      state_in  = state_ff;
      rc_ret_in = rc_ret_ff;
      sd_ret_in = sd_ret_ff;
      sd_dir_in = sd_dir_ff;
      cmd       = '{op: DP_NOP, dir: MOT_IDLE, mcmd: MCMD_NONE, ready: 1'b0, drain: 1'b0};

      unique case (state_ff)
         S_IDLE: begin
            cmd.ready = 1'b1;
            if (stat.req_valid) begin
               cmd.op   = DP_LATCH;
               state_in = stat.req_kind ? S_C_STOP : S_T_BEGIN;
            end
         end

         // control request: stop, then toggle, then target position
         S_C_STOP: begin
            if (stat.stop_req) begin
               sd_dir_in = MOT_IDLE;
               sd_ret_in = S_C_STOPPUB;
               state_in  = S_SD_CHK;
            end else begin
               state_in = S_C_TOG;
            end
         end
         S_C_STOPPUB: begin
            cmd.op   = DP_EMIT;
            state_in = S_C_TOG;
         end
         S_C_TOG: begin
            if (!stat.toggle_req) begin
               state_in = S_C_POS;
            end else if (stat.motion != MOT_IDLE) begin
               sd_dir_in = MOT_IDLE;
               sd_ret_in = S_C_TOGPUB;
               state_in  = S_SD_CHK;
            end else if (stat.win_zero || stat.prior_motion == MOT_CLOSE) begin
               cmd.op    = DP_GOAL_MAX;
               sd_dir_in = MOT_OPEN;
               sd_ret_in = S_C_POS;
               state_in  = S_SD_CHK;
            end else begin
               cmd.op    = DP_GOAL_ZERO;
               sd_dir_in = MOT_CLOSE;
               sd_ret_in = S_C_POS;
               state_in  = S_SD_CHK;
            end
         end
         S_C_TOGPUB: begin
            cmd.op   = DP_EMIT;
            state_in = S_C_POS;
         end
         S_C_POS: begin
            sd_ret_in = S_DRAIN;
            if (!stat.pos_valid) begin
               state_in = S_DRAIN;
            end else if (!stat.p_eq_win) begin
               cmd.op    = DP_GOAL_REQ;
               sd_dir_in = stat.p_lt_win ? MOT_CLOSE : MOT_OPEN;
               state_in  = S_SD_CHK;
            end else if (stat.p_zero || stat.p_max) begin
               cmd.op    = DP_GOAL_REQ;
               sd_dir_in = stat.p_zero ? MOT_CLOSE : MOT_OPEN;
               state_in  = S_SD_CHK;
            end else begin
               state_in = S_DRAIN;
            end
         end

         // tick: end detection first, then position update and target check
         S_T_BEGIN: begin
            if (stat.status_leading) begin
               priority if (stat.locked && stat.motion == MOT_IDLE && !stat.win_zero) begin
                  state_in = S_T_CLOSE;
               end else if (stat.locked && stat.motion == MOT_OPEN && !stat.lock_freed) begin
                  state_in = S_T_RC;
               end else if (stat.locked && stat.motion == MOT_OPEN) begin
                  state_in = S_T_CLOSE;
               end else if (stat.locked && stat.motion == MOT_CLOSE) begin
                  if (stat.prior_max && stat.auto_cal) begin
                     cmd.op = DP_CALIB;
                  end
                  state_in = S_T_CLOSE;
               end else if (stat.unlocked && stat.win_zero && stat.motion == MOT_IDLE) begin
                  if (stat.pub_ok) begin
                     cmd.op   = DP_UNLOCK_START;
                     state_in = S_T_PUBGO;
                  end else begin
                     state_in = S_T_RC;
                  end
               end else if (stat.motion == MOT_IDLE) begin
                  state_in = S_DRAIN;
               end else if (stat.unlocked) begin
                  cmd.op   = DP_FREE;
                  state_in = S_T_RC;
               end else begin
                  state_in = S_T_RC;
               end
            end else if (stat.motion == MOT_OPEN && stat.open_due && stat.pub_ok) begin
               cmd.op   = DP_OPEN_END;
               state_in = S_T_PUBGO;
            end else if (stat.motion == MOT_CLOSE && stat.close_due && stat.pub_ok) begin
               cmd.op   = DP_CLOSE_END;
               state_in = S_T_PUBGO;
            end else begin
               state_in = S_T_RC;
            end
         end
         S_T_CLOSE: begin
            if (stat.pub_ok) begin
               cmd.op   = DP_SET_CLOSED;
               state_in = S_T_PUBEND;
            end else begin
               state_in = S_DRAIN;
            end
         end
         S_T_PUBEND: begin
            cmd.op   = DP_EMIT;
            state_in = S_DRAIN;
         end
         S_T_PUBGO: begin
            cmd.op   = DP_EMIT;
            state_in = S_T_RC;
         end
         S_T_RC: begin
            rc_ret_in = S_T_AT;
            state_in  = S_RC_CHK;
         end
         S_T_AT: begin
            if (!stat.at_goal) begin
               state_in = S_DRAIN;
            end else if (stat.goal_zero) begin
               state_in = S_T_PUBEND;
            end else if (stat.goal_max) begin
               cmd.op   = DP_AT_MAX;
               state_in = S_T_PUBEND;
            end else begin
               sd_dir_in = MOT_IDLE;
               sd_ret_in = S_T_PRIOR;
               state_in  = S_SD_CHK;
            end
         end
         S_T_PRIOR: begin
            cmd.op   = DP_PRIOR_WIN;
            state_in = S_T_PUBEND;
         end

         // direction change: skip a repeat of the running direction
         S_SD_CHK: begin
            if (sd_dir_ff == stat.motion && sd_dir_ff != MOT_IDLE) begin
               state_in = sd_ret_ff;
            end else begin
               rc_ret_in = S_SD_SET;
               state_in  = S_RC_CHK;
            end
         end
         S_SD_SET: begin
            cmd.op   = DP_START;
            cmd.dir  = sd_dir_ff;
            state_in = S_SD_EMIT;
         end
         S_SD_EMIT: begin
            cmd.op = DP_EMIT;
            unique case (sd_dir_ff)
               MOT_OPEN:  cmd.mcmd = MCMD_OPEN;
               MOT_CLOSE: cmd.mcmd = MCMD_CLOSE;
               default:   cmd.mcmd = MCMD_STOP;
            endcase
            state_in = sd_ret_ff;
         end

         // position update from time elapsed since the last update
         S_RC_CHK: begin
            unique case (stat.motion)
               MOT_OPEN: begin
                  cmd.op   = DP_DIV_LOCK;
                  state_in = S_RC_LOCKA;
               end
               MOT_CLOSE: begin
                  cmd.op   = DP_DIV_CLOSE;
                  state_in = S_RC_WINS;
               end
               default: state_in = rc_ret_ff;
            endcase
         end
         S_RC_LOCKA: begin
            if (!stat.div_busy) begin
               cmd.op   = DP_LOCK_ADD;
               state_in = stat.lock_freed ? S_RC_DOPEN : S_RC_END;
            end
         end
         S_RC_DOPEN: begin
            cmd.op   = DP_DIV_OPEN;
            state_in = S_RC_WINA;
         end
         S_RC_WINA: begin
            if (!stat.div_busy) begin
               cmd.op   = DP_WIN_ADD;
               state_in = S_RC_END;
            end
         end
         S_RC_WINS: begin
            if (!stat.div_busy) begin
               cmd.op   = DP_WIN_SUB;
               state_in = S_RC_CHK0;
            end
         end
         S_RC_CHK0: begin
            if (stat.win_zero) begin
               cmd.op   = DP_DIV_LOCK;
               state_in = S_RC_LOCKS;
            end else begin
               state_in = S_RC_END;
            end
         end
         S_RC_LOCKS: begin
            if (!stat.div_busy) begin
               cmd.op   = DP_LOCK_SUB;
               state_in = S_RC_END;
            end
         end
         S_RC_END: begin
            cmd.op   = DP_RC_DONE;
            state_in = rc_ret_ff;
         end

         S_DRAIN: begin
            cmd.drain = 1'b1;
            if (!stat.pending) begin
               cmd.op   = DP_CLEAR;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rc_ret_ff <= S_IDLE;
         sd_ret_ff <= S_IDLE;
         sd_dir_ff <= MOT_IDLE;
      end else begin
         state_ff  <= state_in;
         rc_ret_ff <= rc_ret_in;
         sd_ret_ff <= sd_ret_in;
         sd_dir_ff <= sd_dir_in;
      end
   end

endmodule

// File: sv/cover_position_estimator.sv
// Cover position estimator: dead-reckoning window and lock position tracker.
// Depends on cpe_pkg, cpe_if, cpe_ctrl and cpe_dp.
//
// req carries ticks (kind 0, with the polled lock status) and control
// requests (kind 1: stop, toggle, target position). rsp returns zero to
// four items per request, motor commands and publishes, with last set on
// the final one; a request that causes nothing returns no item.
// One request is in work at a time: req.ready is high only while the block
// waits for a new item. A request runs a sequence of controller steps plus,
// for each position division, a check step in the shared divider and then
// its 16 quotient bits one after another, unless the quotient already
// saturates at the check. A request runs at most two position updates of two
// divisions each, and its first result is only offered once the whole
// request has been worked through.
// Results are held in a four-entry buffer and drained in order; while the
// receiver holds rsp.ready low the block waits and takes no new request.
// Reset returns the window to closed and locked, idle, with status-leading
// mode, no calibration and a 60000 ms full close time. Configuration is
// written over the APB port (psel, penable, pwrite, paddr, pwdata); the user must
// write it only while the block is idle, which the block does not enforce; pready is always high.
module cover_position_estimator import cpe_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   cpe_req_if.sink          req,
   cpe_rsp_if.source        rsp,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [AddrW-1:0] paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   assign pready = 1'b1;

   cpe_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   cpe_dp u_dp (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .stat    (stat),
      .req     (req),
      .rsp     (rsp),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata)
   );

endmodule

// File: tb/cpe_checker.sv
// Checker for the cover position estimator: watches the request, result and
// APB channels, predicts every result item and compares. Depends on cpe_pkg, cpe_if.
module cpe_checker import cpe_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   cpe_req_if               req,
   cpe_rsp_if               rsp,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [AddrW-1:0] paddr,
   input  logic [31:0]      pwdata,
   output int               failures,
   output int               outstanding,
   output int               results_seen
);

   typedef struct packed {
      mcmd_type           mcmd;
      logic               publish;
      logic [PosBits-1:0] pos;
      logic [PosBits-1:0] lock;
      motion_type         motion;
      logic               last;
   } motor_result_type;

   motor_result_type expected_results[$];
   motor_result_type step_buf[MaxRes];
   int               step_cnt;

   logic               lead_mode, auto_cal;
   logic [DurBits-1:0] full_close, dur_open, dur_close, dur_lock;
   logic [PosBits-1:0] win, lck, prior, goal;
   motion_type         mot, pmot;
   logic               freed;
   logic [31:0]        t_open, t_close, t_rc, t_pub;

   function automatic void push_result(mcmd_type c, logic pub);
      if (step_cnt < MaxRes) begin
         step_buf[step_cnt] = '{c, pub, win, lck, mot, 1'b0};
         step_cnt++;
      end
   endfunction

   function automatic void set_dur(longint unsigned x);
      if (x > DurMax) x = DurMax;
      dur_open  = DurBits'((x * 7) / 10);
      dur_close = dur_open;
      dur_lock  = DurBits'((x * 3) / 10);
   endfunction

   function automatic logic [PosBits-1:0] travel(logic [31:0] el, logic [DurBits-1:0] d);
      longint unsigned q;
      if (d == 0) return PosMax;
      q = (longint'(el) * PosMaxL) / d;
      return (q > PosMaxL) ? PosMax : PosBits'(q);
   endfunction

   function automatic logic [PosBits-1:0] up(logic [PosBits-1:0] a, logic [PosBits-1:0] b);
      return ({1'b0, a} + b > PosMaxL) ? PosMax : a + b;
   endfunction

   function automatic logic [PosBits-1:0] down(logic [PosBits-1:0] a, logic [PosBits-1:0] b);
      return (b >= a) ? '0 : a - b;
   endfunction

   function automatic void advance(logic [31:0] now);
      logic [31:0] el;
      if (mot == MOT_IDLE) return;
      el = now - t_rc;
      if (mot == MOT_OPEN) begin
         lck = up(lck, travel(el, dur_lock));
         if (freed) win = up(win, travel(el, dur_open));
      end else begin
         win = down(win, travel(el, dur_close));
         if (win == 0) lck = down(lck, travel(el, dur_lock));
      end
      t_rc = now;
   endfunction

   function automatic void drive_to(motion_type dir, logic [31:0] now);
      if (dir == mot && dir != MOT_IDLE) return;
      advance(now);
      mot  = dir;
      t_rc = now;
      case (dir)
         MOT_IDLE: begin
            prior = win;
            push_result(MCMD_STOP, 1'b0);
         end
         MOT_OPEN: begin
            pmot = dir;
            if (win > 0) prior = win;
            t_open = now;
            push_result(MCMD_OPEN, 1'b0);
         end
         default: begin
            pmot = dir;
            if (win < PosMax) prior = win;
            t_close = now;
            push_result(MCMD_CLOSE, 1'b0);
         end
      endcase
   endfunction

   function automatic void mark_closed(logic [31:0] now);
      win = 0; prior = 0; lck = 0; freed = 0;
      mot = MOT_IDLE;
      push_result(MCMD_NONE, 1'b1);
      t_pub = now;
   endfunction

   function automatic void on_tick(logic [31:0] now, logic [1:0] st);
      logic locked, unl, pub_ok, at;
      logic [31:0] meas;
      locked = (st == StStrong) || (st == StWeak);
      unl    = (st == StUnlocked);
      pub_ok = (now - t_pub) > PubHoldMs;
      if (lead_mode) begin
         if (locked && mot == MOT_IDLE && win != 0) begin
            if (pub_ok) mark_closed(now);
            return;
         end else if (locked && mot == MOT_OPEN && !freed) begin
            // lock still travelling: locked status is expected
         end else if (locked && mot == MOT_OPEN) begin
            if (pub_ok) mark_closed(now);
            return;
         end else if (locked && mot == MOT_CLOSE) begin
            if (prior == PosMax && auto_cal) begin
               // measured time wraps at 32 bits
               meas = now - t_close;
               set_dur(meas);
            end
            if (pub_ok) mark_closed(now);
            return;
         end else if (unl && win == 0 && mot == MOT_IDLE) begin
            if (pub_ok) begin
               prior = 0; mot = MOT_OPEN; lck = LockStartPos;
               t_open = now; t_rc = now;
               push_result(MCMD_NONE, 1'b1);
               t_pub = now;
            end
         end else if (mot == MOT_IDLE) begin
            return;
         end else if (unl) begin
            freed = 1;
         end
      end else if (mot == MOT_OPEN) begin
         if ((now - t_open) >= dur_open && pub_ok) begin
            win = PosMax; prior = PosMax; mot = MOT_IDLE;
            push_result(MCMD_NONE, 1'b1);
            t_pub = now;
         end
      end else if (mot == MOT_CLOSE) begin
         if ((now - t_close) >= dur_close && pub_ok) begin
            win = 0; prior = 0; mot = MOT_IDLE;
            push_result(MCMD_NONE, 1'b1);
            t_pub = now;
         end
      end
      advance(now);
      if (mot == MOT_OPEN) at = win >= goal;
      else if (mot == MOT_CLOSE) at = win <= goal;
      else at = 1;
      if (at) begin
         if (goal == 0) begin
            // closing to zero is not stopped here; it ends on the locked status or the close time
         end else if (goal == PosMax) begin
            mot = MOT_IDLE; prior = PosMax;
         end else begin
            drive_to(MOT_IDLE, now);
            prior = win;
         end
         push_result(MCMD_NONE, 1'b1);
      end
   endfunction

   function automatic void on_control(logic [31:0] now, logic s, logic t, logic pv,
                                      logic [PosBits-1:0] p);
      if (s) begin
         drive_to(MOT_IDLE, now);
         push_result(MCMD_NONE, 1'b1);
      end
      if (t) begin
         if (mot != MOT_IDLE) begin
            drive_to(MOT_IDLE, now);
            push_result(MCMD_NONE, 1'b1);
         end else if (win == 0 || pmot == MOT_CLOSE) begin
            goal = PosMax;
            drive_to(MOT_OPEN, now);
         end else begin
            goal = 0;
            drive_to(MOT_CLOSE, now);
         end
      end
      if (pv) begin
         if (p == win) begin
            if (p == PosMax || p == 0) begin
               goal = p;
               drive_to((p == 0) ? MOT_CLOSE : MOT_OPEN, now);
            end
         end else begin
            goal = p;
            drive_to((p < win) ? MOT_CLOSE : MOT_OPEN, now);
         end
      end
   endfunction

   assign outstanding = expected_results.size();

   always @(posedge clock) begin
      motor_result_type got, want;
      if (reset) begin
         lead_mode = 1; auto_cal = 0; full_close = FullCloseInit;
         set_dur(FullCloseReset);
         win = 0; lck = 0; prior = 0; goal = 0;
         mot = MOT_IDLE; pmot = MOT_IDLE; freed = 0;
         t_open = 0; t_close = 0; t_rc = 0; t_pub = 0;
         expected_results.delete();
         failures     = 0;
         results_seen = 0;
      end else begin
         if (psel && penable && pwrite) begin
            case (paddr[3:2])
               CSR_STATUS_LEADING: lead_mode = pwdata[0];
               CSR_AUTO_CAL:       auto_cal  = pwdata[0];
               CSR_FULL_CLOSE: begin
                  full_close = pwdata[DurBits-1:0];
                  set_dur(full_close);
               end
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            results_seen++;
            got = '{mcmd_type'(rsp.motor_command), rsp.publish, rsp.position,
                    rsp.lock_position, motion_type'(rsp.operation), rsp.last};
            if (expected_results.size() == 0) begin
               failures++;
               $display("%0t: unexpected result item %p", $time, got);
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  failures++;
                  $display("%0t: result mismatch expected %p actual %p", $time, want, got);
               end
            end
         end
         if (req.valid && req.ready) begin
            step_cnt = 0;
            if (req.kind)
               on_control(req.now_ms, req.stop_request, req.toggle_request,
                          req.position_valid, req.requested_position);
            else
               on_tick(req.now_ms, req.status_code);
            if (step_cnt > 0) step_buf[step_cnt-1].last = 1'b1;
            for (int i = 0; i < step_cnt; i++) expected_results.push_back(step_buf[i]);
         end
      end
   end

endmodule

// File: tb/testbench.sv
// Top of the cover position estimator testbench: clock, reset, stimulus, APB
// writes and verdict. Depends on cpe_pkg, cpe_if, cpe_checker and the block.
module testbench;
   import cpe_pkg::*;

   logic             clock = 0;
   logic             reset = 1;
   logic             psel = 0, penable = 0, pwrite = 0;
   logic [AddrW-1:0] paddr = '0;
   logic [31:0]      pwdata = '0;
   logic [31:0]      prdata;
   logic             pready;
   int               failures, outstanding, results_seen;
   int               items_sent = 0;
   logic             no_gaps = 0;
   logic [31:0]      clock_ms = 0;

   cpe_req_if req();
   cpe_rsp_if rsp();

   cover_position_estimator u_dut (
      .clock, .reset, .req(req.sink), .rsp(rsp.source),
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   cpe_checker u_checker (
      .clock, .reset, .req, .rsp, .psel, .penable, .pwrite, .paddr, .pwdata,
      .failures, .outstanding, .results_seen
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   initial begin
      req.valid = 0; req.kind = 0; req.now_ms = 0; req.status_code = 0;
      req.stop_request = 0; req.toggle_request = 0; req.position_valid = 0;
      req.requested_position = 0;
      rsp.ready = 0;
   end

   // result side: stall a random number of cycles before each item
   initial begin
      int stall;
      @(posedge clock iff !reset);
      forever begin
         stall = no_gaps ? 0 : $urandom_range(0, 16);
         if (stall > 0) begin
            rsp.ready <= 0;
            repeat (stall) @(posedge clock);
         end
         rsp.ready <= 1;
         @(posedge clock);
         while (!rsp.valid) @(posedge clock);
      end
   end

   task automatic send(logic k, logic [31:0] t, logic [1:0] st, logic s, logic tg,
                       logic pv, logic [15:0] p);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1; req.kind <= k; req.now_ms <= t; req.status_code <= st;
      req.stop_request <= s; req.toggle_request <= tg; req.position_valid <= pv;
      req.requested_position <= p;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic tick(int step, logic [1:0] st);
      clock_ms += step;
      send(1'b0, clock_ms, st, $urandom, $urandom, $urandom, $urandom);
   endtask

   task automatic ctrl(int step, logic s, logic tg, logic pv, logic [15:0] p);
      clock_ms += step;
      send(1'b1, clock_ms, $urandom, s, tg, pv, p);
   endtask

   // wait for every expected item, then for a possible silent item in work
   task automatic settle();
      req.valid <= 0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic csr_write(csr_idx_type idx, logic [31:0] val);
      psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      @(posedge clock);
   endtask

   task automatic random_run(int n);
      int r;
      logic [15:0] p;
      for (int i = 0; i < n; i++) begin
         no_gaps = ((i / 20) % 3 == 2);
         r = $urandom_range(0, 15);
         if (r == 0) clock_ms = $urandom;
         if (r < 11) begin
            // status mostly unlocked or locked so motions actually end
            tick($urandom_range(0, 2500), $urandom_range(0, 3));
         end else begin
            case ($urandom_range(0, 3))
               0: p = 16'h0000;
               1: p = 16'hFFFF;
               default: p = $urandom;
            endcase
            ctrl($urandom_range(0, 2500), $urandom_range(0, 5) == 0,
                 $urandom_range(0, 2) == 0, $urandom_range(0, 1), p);
         end
      end
      settle();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: open from closed, lock release, target, stop, close, wrap
      ctrl(2000, 0, 1, 0, 16'h0000);
      tick(1500, StUnlocked);
      tick(1500, StUnlocked);
      tick(1500, StStrong);
      ctrl(1200, 0, 0, 1, 16'h8000);
      tick(1100, 2'd0);
      ctrl(1100, 1, 0, 0, 16'h0000);
      ctrl(1100, 0, 0, 1, 16'hFFFF);
      tick(1100, StUnlocked);
      tick(40000, StUnlocked);
      ctrl(1100, 0, 1, 0, 16'h0000);
      ctrl(1100, 0, 1, 0, 16'h0000);
      tick(50000, StWeak);
      tick(10, StWeak);
      tick(1500, StUnlocked);
      ctrl(1100, 1, 1, 1, 16'hFFFF);
      ctrl(1100, 0, 0, 1, 16'h0000);
      clock_ms = 32'hFFFF_FF00;
      tick(0, StUnlocked);
      tick(32'h0000_0500, StStrong);
      ctrl(1100, 1, 1, 1, 16'h1234);
      tick(0, 2'd0);
      settle();

      csr_write(CSR_STATUS_LEADING, 32'h0);
      csr_write(CSR_AUTO_CAL, 32'h1);
      csr_write(CSR_FULL_CLOSE, 32'd1000);
      random_run(40);

      csr_write(CSR_STATUS_LEADING, 32'hFFFF_FFFF);
      csr_write(CSR_FULL_CLOSE, 32'd3000);
      random_run(45);

      csr_write(CSR_FULL_CLOSE, 32'd600000);
      random_run(25);

      csr_write(CSR_AUTO_CAL, 32'h0);
      csr_write(CSR_STATUS_LEADING, 32'h0);
      csr_write(CSR_FULL_CLOSE, 32'hFFF0_2000);
      random_run(25);

      csr_write(CSR_STATUS_LEADING, 32'h1);
      csr_write(CSR_FULL_CLOSE, 32'd60000);
      random_run(25);

      $display("run covered %0d request items and %0d result items", items_sent,
               results_seen);
      $display("over timing and status-leading modes, with and without calibration");
      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("status: fail");
      $finish;
   end

endmodule
